@@ rtl/core/dsa_pkg.sv @@
package dsa_pkg;

   // Offset arithmetic width inside the managed region
   localparam int OFF_W   = 29;
   localparam int SUM_W   = OFF_W + 2;
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 28;
   localparam int TOTAL_W = 29;

   localparam int PERM_ALIGN = 31;
   localparam int TEMP_ALIGN = 7;
   localparam int HDR_BYTES  = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(134217728);

   // Request codes
   localparam logic [2:0] OP_ALLOC_PERM = 3'd0;
   localparam logic [2:0] OP_ALLOC_TEMP = 3'd1;
   localparam logic [2:0] OP_FREE_TEMP  = 3'd2;
   localparam logic [2:0] OP_CLR_TEMP   = 3'd3;
   localparam logic [2:0] OP_SET_MARK   = 3'd4;
   localparam logic [2:0] OP_CLR_MARK   = 3'd5;
   localparam logic [2:0] OP_CLR_ALL    = 3'd6;

   // Permanent side preference
   localparam logic [1:0] PREF_LOW  = 2'd0;
   localparam logic [1:0] PREF_HIGH = 2'd1;
   localparam logic [1:0] PREF_ANY  = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_NOT_TOP  = 2'd2;

   // Register index (word address bit)
   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_TOTAL = 1'b1;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [SIZE_W-1:0]  alloc_size;
      logic [1:0]         preference;
      logic [ADDR_W-1:0]  buffer_address;
      logic [TOTAL_W-1:0] recorded_size;
   } dsa_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [ADDR_W-1:0]  address;
      logic [TOTAL_W-1:0] remaining;
      logic               mark_set;
   } dsa_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWAP,
      ST_CHECK,
      ST_COMMIT,
      ST_USAGE,
      ST_REPORT
   } dsa_state_type;

   typedef struct packed {
      logic load;
      logic swap;
      logic check;
      logic commit;
      logic usage;
      logic report;
   } dsa_cmd_type;

   typedef struct packed {
      logic fail;
   } dsa_stat_type;

endpackage

@@ rtl/core/dsa_ctrl.sv @@
module dsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  dsa_pkg::dsa_stat_type stat,
   output logic                  busy,
   output dsa_pkg::dsa_cmd_type  cmd
);
   import dsa_pkg::*;

   dsa_state_type state_ff;
   dsa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP:   state_in = ST_CHECK;
         // skip the commit when the space check fails or a free is larger than the temp stack
         ST_CHECK:  state_in = stat.fail ? ST_USAGE : ST_COMMIT;
         ST_COMMIT: state_in = ST_USAGE;
         ST_USAGE:  state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SWAP:   cmd.swap   = 1'b1;
         ST_CHECK:  cmd.check  = 1'b1;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_USAGE:  cmd.usage  = 1'b1;
         ST_REPORT: cmd.report = 1'b1;
         default:   busy       = 1'b1;
      endcase
   end

endmodule

@@ rtl/core/dsa_dpath.sv @@
module dsa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  dsa_pkg::dsa_cmd_type                cmd,
   output dsa_pkg::dsa_stat_type               stat,
   input  dsa_pkg::dsa_req_type                req_data,
   input  logic [dsa_pkg::ADDR_W-1:0]          base_addr,
   input  logic [dsa_pkg::TOTAL_W-1:0]         total_size,
   output logic                                rsp_valid,
   output dsa_pkg::dsa_rsp_type                rsp_data
);
   import dsa_pkg::*;

   // Allocator state
   logic [OFF_W-1:0] low_mark_ff,  low_mark_in;
   logic [OFF_W-1:0] low_perm_ff,  low_perm_in;
   logic [OFF_W-1:0] low_temp_ff,  low_temp_in;
   logic [OFF_W-1:0] low_hw_ff,    low_hw_in;
   logic [OFF_W-1:0] high_mark_ff, high_mark_in;
   logic [OFF_W-1:0] high_perm_ff, high_perm_in;
   logic [OFF_W-1:0] high_temp_ff, high_temp_in;
   logic [OFF_W-1:0] high_hw_ff,   high_hw_in;
   logic             perm_low_ff,  perm_low_in;

   // Working registers for one request
   logic [2:0]        op_ff,     op_in;
   logic [1:0]        pref_ff,   pref_in;
   logic [OFF_W-1:0]  size_ff,   size_in;
   logic [OFF_W-1:0]  rsz_ff,    rsz_in;
   logic [ADDR_W-1:0] hdr_ff,    hdr_in;
   logic              plow_ff,   plow_in;
   logic              fail_ff,   fail_in;
   logic [OFF_W-1:0]  noff_ff,   noff_in;
   logic [1:0]        status_ff, status_in;
   logic [ADDR_W-1:0] addr_ff,   addr_in;
   logic [OFF_W:0]    used_ff,   used_in;
   logic [ADDR_W-1:0] end_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   dsa_rsp_type       rsp_ff,    rsp_in;

   logic [OFF_W-1:0]  perm_round;
   logic [OFF_W-1:0]  temp_round;
   logic              try_swap;
   logic [OFF_W-1:0]  perm_p, perm_h, oth_p, oth_t, oth_h;
   logic signed [OFF_W:0] waste_oth, waste_perm;
   logic              swap_ok;
   logic [OFF_W-1:0]  p_pi, p_ti, t_ti;
   logic [SUM_W-1:0]  need_perm, need_temp;
   logic              fail_c;
   logic              use_low;
   logic [OFF_W-1:0]  addr_off;
   logic [ADDR_W-1:0] addr_sum;
   logic [OFF_W-1:0]  lo_use, hi_use;

   // Rounded sizes: temp includes its header
   assign perm_round = (OFF_W'(req_data.alloc_size) + OFF_W'(PERM_ALIGN))
                       & ~OFF_W'(PERM_ALIGN);
   assign temp_round = (OFF_W'(req_data.alloc_size) + OFF_W'(TEMP_ALIGN + HDR_BYTES))
                       & ~OFF_W'(TEMP_ALIGN);

   // Swap decision, evaluated on the current roles
   assign try_swap = (op_ff == OP_ALLOC_TEMP) ||
                     ((op_ff == OP_ALLOC_PERM) &&
                      ((pref_ff == PREF_ANY) ||
                       ((pref_ff == PREF_LOW) && !perm_low_ff) ||
                       ((pref_ff == PREF_HIGH) && perm_low_ff)));
   assign perm_p = perm_low_ff ? low_perm_ff  : high_perm_ff;
   assign perm_h = perm_low_ff ? low_hw_ff    : high_hw_ff;
   assign oth_p  = perm_low_ff ? high_perm_ff : low_perm_ff;
   assign oth_t  = perm_low_ff ? high_temp_ff : low_temp_ff;
   assign oth_h  = perm_low_ff ? high_hw_ff   : low_hw_ff;
   assign waste_oth  = $signed({1'b0, oth_h})  - $signed({1'b0, oth_p});
   assign waste_perm = $signed({1'b0, perm_h}) - $signed({1'b0, perm_p});
   assign swap_ok = try_swap && (oth_t == oth_p) && (waste_oth > waste_perm);

   // Operands on the working roles
   assign p_pi = plow_ff ? low_perm_ff  : high_perm_ff;
   assign p_ti = plow_ff ? high_perm_ff : low_perm_ff;
   assign t_ti = plow_ff ? high_temp_ff : low_temp_ff;

   assign need_perm = SUM_W'(low_temp_ff) + SUM_W'(high_temp_ff) + SUM_W'(size_ff);
   assign need_temp = SUM_W'(t_ti) + SUM_W'(p_pi) + SUM_W'(size_ff);

   always_comb begin
      case (op_ff)
         OP_ALLOC_PERM: fail_c = need_perm > SUM_W'(total_size);
         OP_ALLOC_TEMP: fail_c = need_temp > SUM_W'(total_size);
         OP_FREE_TEMP:  fail_c = rsz_ff > t_ti;
         default:       fail_c = 1'b0;
      endcase
   end

   assign stat.fail = fail_c;

   // Shared address adder: low end counts up from base, high end down from the end
   always_comb begin
      case (op_ff)
         OP_ALLOC_PERM: begin
            use_low  = plow_ff;
            addr_off = plow_ff ? low_perm_ff : noff_ff;
         end
         OP_ALLOC_TEMP: begin
            use_low  = !plow_ff;
            addr_off = plow_ff ? noff_ff : low_temp_ff;
         end
         default: begin
            use_low  = !plow_ff;
            addr_off = plow_ff ? high_temp_ff : noff_ff;
         end
      endcase
   end

   assign addr_sum = use_low ? (base_addr + ADDR_W'(addr_off))
                             : (end_ff - ADDR_W'(addr_off));

   assign lo_use = (low_perm_ff > low_temp_ff)   ? low_perm_ff  : low_temp_ff;
   assign hi_use = (high_perm_ff > high_temp_ff) ? high_perm_ff : high_temp_ff;

   always_comb begin
      low_mark_in  = low_mark_ff;
      low_perm_in  = low_perm_ff;
      low_temp_in  = low_temp_ff;
      low_hw_in    = low_hw_ff;
      high_mark_in = high_mark_ff;
      high_perm_in = high_perm_ff;
      high_temp_in = high_temp_ff;
      high_hw_in   = high_hw_ff;
      perm_low_in  = perm_low_ff;
      op_in        = op_ff;
      pref_in      = pref_ff;
      size_in      = size_ff;
      rsz_in       = rsz_ff;
      hdr_in       = hdr_ff;
      plow_in      = plow_ff;
      fail_in      = fail_ff;
      noff_in      = noff_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      used_in      = used_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = cmd.report;

      if (cmd.load) begin
         op_in     = req_data.req_type;
         pref_in   = req_data.preference;
         size_in   = (req_data.req_type == OP_ALLOC_TEMP) ? temp_round : perm_round;
         rsz_in    = OFF_W'(req_data.recorded_size);
         hdr_in    = req_data.buffer_address - ADDR_W'(HDR_BYTES);
         status_in = STATUS_OK;
         addr_in   = '0;
      end

      if (cmd.swap) begin
         plow_in = swap_ok ? !perm_low_ff : perm_low_ff;
      end

      if (cmd.check) begin
         fail_in = fail_c;
         case (op_ff)
            OP_ALLOC_PERM: noff_in = p_pi + size_ff;
            OP_ALLOC_TEMP: noff_in = t_ti + size_ff;
            OP_FREE_TEMP:  noff_in = t_ti - rsz_ff;
            default:       noff_in = '0;
         endcase
         if (fail_c) begin
            status_in = (op_ff == OP_FREE_TEMP) ? STATUS_NOT_TOP : STATUS_NO_SPACE;
         end
      end

      if (cmd.commit) begin
         case (op_ff)
            OP_ALLOC_PERM: begin
               addr_in     = addr_sum;
               perm_low_in = plow_ff;
               if (plow_ff) begin
                  low_perm_in = noff_ff;
                  low_temp_in = noff_ff;
               end else begin
                  high_perm_in = noff_ff;
                  high_temp_in = noff_ff;
               end
            end
            OP_ALLOC_TEMP: begin
               addr_in     = addr_sum;
               perm_low_in = plow_ff;
               if (plow_ff) begin
                  high_temp_in = noff_ff;
                  if (noff_ff > high_hw_ff) begin
                     high_hw_in = noff_ff;
                  end
               end else begin
                  low_temp_in = noff_ff;
                  if (noff_ff > low_hw_ff) begin
                     low_hw_in = noff_ff;
                  end
               end
            end
            OP_FREE_TEMP: begin
               // pop only when the header sits at the top of the temp stack
               if (hdr_ff == addr_sum) begin
                  if (plow_ff) begin
                     high_temp_in = noff_ff;
                  end else begin
                     low_temp_in = noff_ff;
                  end
               end else begin
                  status_in = STATUS_NOT_TOP;
               end
            end
            OP_CLR_TEMP: begin
               if (plow_ff) begin
                  high_temp_in = p_ti;
               end else begin
                  low_temp_in = p_ti;
               end
            end
            OP_SET_MARK: begin
               low_mark_in  = low_perm_ff;
               high_mark_in = high_perm_ff;
            end
            OP_CLR_MARK: begin
               low_perm_in  = low_mark_ff;
               low_temp_in  = low_mark_ff;
               high_perm_in = high_mark_ff;
               high_temp_in = high_mark_ff;
            end
            OP_CLR_ALL: begin
               low_mark_in  = '0;
               low_perm_in  = '0;
               low_temp_in  = '0;
               low_hw_in    = '0;
               high_mark_in = '0;
               high_perm_in = '0;
               high_temp_in = '0;
               high_hw_in   = '0;
               perm_low_in  = 1'b1;
            end
            default: begin
               addr_in = addr_ff;
            end
         endcase
      end

      if (cmd.usage) begin
         // step past the header of a granted temp buffer
         if ((op_ff == OP_ALLOC_TEMP) && !fail_ff) begin
            addr_in = addr_ff + ADDR_W'(HDR_BYTES);
         end
         used_in = {1'b0, lo_use} + {1'b0, hi_use};
      end

      if (cmd.report) begin
         rsp_in.status    = status_ff;
         rsp_in.address   = addr_ff;
         rsp_in.remaining = (used_ff >= (OFF_W + 1)'(total_size)) ? '0
                            : TOTAL_W'((OFF_W + 1)'(total_size) - used_ff);
         rsp_in.mark_set  = (low_mark_ff != '0) || (high_mark_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_mark_ff  <= '0;
         low_perm_ff  <= '0;
         low_temp_ff  <= '0;
         low_hw_ff    <= '0;
         high_mark_ff <= '0;
         high_perm_ff <= '0;
         high_temp_ff <= '0;
         high_hw_ff   <= '0;
         perm_low_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_mark_ff  <= low_mark_in;
         low_perm_ff  <= low_perm_in;
         low_temp_ff  <= low_temp_in;
         low_hw_ff    <= low_hw_in;
         high_mark_ff <= high_mark_in;
         high_perm_ff <= high_perm_in;
         high_temp_ff <= high_temp_in;
         high_hw_ff   <= high_hw_in;
         perm_low_ff  <= perm_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pref_ff   <= pref_in;
      size_ff   <= size_in;
      rsz_ff    <= rsz_in;
      hdr_ff    <= hdr_in;
      plow_ff   <= plow_in;
      fail_ff   <= fail_in;
      noff_ff   <= noff_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
      used_ff   <= used_in;
      rsp_ff    <= rsp_in;
      end_ff    <= base_addr + ADDR_W'(total_size);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/double_ended_stack_allocator.sv @@
// Channel   Ports                                    Direction  Handshake
// request   start, busy, req_data                    in         start & !busy
// result    rsp_valid, rsp_data                      out        one-cycle strobe
// config    psel, penable, pwrite, paddr, pwdata,    in/out     APB, pready tied high
//           prdata, pready
//
// A request runs from its accepting edge through the swap, check, commit, usage and report
// steps before the next can be accepted (commit is skipped when an allocation runs out of
// space or a free is larger than the temp stack; a free whose header is not on top still
// takes the commit step); the sequencer walks these steps over a single set of offset adders.
// The result strobe is high in the cycle after the report step, during which the
// next request may already be accepted. The receiver cannot stall results.
// Synchronous reset empties both stacks, makes the low end permanent, zeroes the
// base address and sets the region size to 128 MiB.
module double_ended_stack_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  dsa_pkg::dsa_req_type               req_data,
   output logic                               rsp_valid,
   output dsa_pkg::dsa_rsp_type               rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [dsa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dsa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dsa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import dsa_pkg::*;

   logic [ADDR_W-1:0]  base_ff,  base_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               csr_wr;
   logic               csr_sel;
   dsa_cmd_type        cmd;
   dsa_stat_type       stat;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = paddr[CSR_ADDR_W-1];

   always_comb begin
      base_in  = base_ff;
      total_in = total_ff;
      if (csr_wr) begin
         unique case (csr_sel)
            REG_BASE:  base_in  = pwdata;
            REG_TOTAL: total_in = pwdata[TOTAL_W-1:0];
            default:   base_in  = base_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_BASE:  prdata = base_ff;
         REG_TOTAL: prdata = CSR_DATA_W'(total_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         total_ff <= TOTAL_RESET;
      end else begin
         base_ff  <= base_in;
         total_ff <= total_in;
      end
   end

   dsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   dsa_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .base_addr  (base_ff),
      .total_size (total_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

@@ verif/dsa_scoreboard.sv @@
`timescale 1ns / 100ps

package dsa_tb_pkg;
   import dsa_pkg::*;

   // Codes outside the documented set, still reachable through the field widths
   localparam logic [2:0] OP_UNDEFINED = 3'd7;
   localparam logic [1:0] PREF_NONE    = 2'd3;

   localparam logic [63:0] OFF_MASK = (64'd1 << OFF_W) - 64'd1;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [TOTAL_W-1:0] span;
   } temp_block_type;

   class alloc_scoreboard;
      logic [ADDR_W-1:0]  base_addr;
      logic [TOTAL_W-1:0] region_size;
      logic [63:0]        mark_off[2];
      logic [63:0]        perm_off[2];
      logic [63:0]        temp_off[2];
      logic [63:0]        hw_off[2];
      bit                 perm_low;
      dsa_rsp_type        expected_q[$];
      int                 errors;
      int                 checked;

      function new();
         base_addr   = '0;
         region_size = TOTAL_RESET;
         errors      = 0;
         checked     = 0;
         clear_stacks();
      endfunction

      function void clear_stacks();
         mark_off = '{64'd0, 64'd0};
         perm_off = '{64'd0, 64'd0};
         temp_off = '{64'd0, 64'd0};
         hw_off   = '{64'd0, 64'd0};
         perm_low = 1'b1;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_BASE)
            base_addr = value[ADDR_W-1:0];
         else
            region_size = value[TOTAL_W-1:0];
      endfunction

      // Low end counts up from the base, high end down from base + size
      function logic [ADDR_W-1:0] end_address(int side, logic [63:0] off);
         logic [63:0] a;
         if (side == 0)
            a = 64'(base_addr) + off;
         else
            a = 64'(base_addr) + 64'(region_size) - off;
         return a[ADDR_W-1:0];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function dsa_rsp_type note_request(dsa_req_type r);
         logic [63:0]       m[2], p[2], t[2], h[2];
         logic [63:0]       asz, rsz, span, lo, hi, used;
         logic [ADDR_W-1:0] addr, hdr32, top32;
         logic [1:0]        status;
         longint            waste_t, waste_p;
         int                pi, ti;
         bit                try_swap;
         dsa_rsp_type       e;
         m = mark_off;
         p = perm_off;
         t = temp_off;
         h = hw_off;
         asz = 64'(r.alloc_size);
         rsz = 64'(r.recorded_size);
         addr = '0;
         status = STATUS_OK;
         pi = perm_low ? 0 : 1;
         try_swap = 1'b0;
         if (r.req_type == OP_ALLOC_PERM)
            try_swap = (r.preference == PREF_ANY) ||
                       (r.preference == PREF_LOW && pi != 0) ||
                       (r.preference == PREF_HIGH && pi == 0);
         else if (r.req_type == OP_ALLOC_TEMP)
            try_swap = 1'b1;
         // move the permanent role only onto an empty temp end with more waste
         if (try_swap) begin
            ti = 1 - pi;
            waste_t = longint'(h[ti]) - longint'(p[ti]);
            waste_p = longint'(h[pi]) - longint'(p[pi]);
            if (t[ti] == p[ti] && waste_t > waste_p)
               pi = ti;
         end
         ti = 1 - pi;

         case (r.req_type)
            OP_ALLOC_PERM: begin
               span = (asz + 64'(PERM_ALIGN)) & ~64'(PERM_ALIGN);
               if (t[0] + t[1] + span > 64'(region_size)) begin
                  status = STATUS_NO_SPACE;
               end else begin
                  if (pi == 0) begin
                     addr = end_address(0, p[0]);
                     p[0] = (p[0] + span) & OFF_MASK;
                  end else begin
                     p[1] = (p[1] + span) & OFF_MASK;
                     addr = end_address(1, p[1]);
                  end
                  t[pi] = p[pi];
                  perm_low = (pi == 0);
               end
            end
            OP_ALLOC_TEMP: begin
               span = ((asz + 64'(TEMP_ALIGN)) & ~64'(TEMP_ALIGN)) + 64'(HDR_BYTES);
               if (t[ti] + p[pi] + span > 64'(region_size)) begin
                  status = STATUS_NO_SPACE;
               end else begin
                  if (ti == 0) begin
                     addr = end_address(0, t[0]);
                     t[0] = (t[0] + span) & OFF_MASK;
                  end else begin
                     t[1] = (t[1] + span) & OFF_MASK;
                     addr = end_address(1, t[1]);
                  end
                  addr = addr + ADDR_W'(HDR_BYTES);
                  if (t[ti] > h[ti])
                     h[ti] = t[ti];
                  perm_low = (pi == 0);
               end
            end
            OP_FREE_TEMP: begin
               hdr32 = r.buffer_address - ADDR_W'(HDR_BYTES);
               if (rsz > t[ti]) begin
                  status = STATUS_NOT_TOP;
               end else begin
                  if (ti == 0)
                     top32 = end_address(0, t[0] - rsz);
                  else
                     top32 = end_address(1, t[1]);
                  if (hdr32 == top32)
                     t[ti] = t[ti] - rsz;
                  else
                     status = STATUS_NOT_TOP;
               end
            end
            OP_CLR_TEMP: begin
               t[ti] = p[ti];
            end
            OP_SET_MARK: begin
               m[0] = p[0];
               m[1] = p[1];
            end
            OP_CLR_MARK: begin
               p[0] = m[0];
               t[0] = m[0];
               p[1] = m[1];
               t[1] = m[1];
            end
            OP_CLR_ALL: begin
               m = '{64'd0, 64'd0};
               p = '{64'd0, 64'd0};
               t = '{64'd0, 64'd0};
               h = '{64'd0, 64'd0};
               perm_low = 1'b1;
            end
            default: ;
         endcase

         mark_off = m;
         perm_off = p;
         temp_off = t;
         hw_off   = h;

         lo = (p[0] > t[0]) ? p[0] : t[0];
         hi = (p[1] > t[1]) ? p[1] : t[1];
         used = lo + hi;

         e.status    = status;
         e.address   = addr;
         e.remaining = (used >= 64'(region_size)) ? '0 : TOTAL_W'(64'(region_size) - used);
         e.mark_set  = (m[0] != 0 || m[1] != 0);
         expected_q.push_back(e);
         return e;
      endfunction

      function void check_result(dsa_rsp_type got);
         dsa_rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no request outstanding: status %0d address %h",
                     $time, got.status, got.address);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         end
         if (got.address !== want.address) begin
            errors++;
            $display("%0t: address expected %h actual %h", $time, want.address, got.address);
         end
         if (got.remaining !== want.remaining) begin
            errors++;
            $display("%0t: remaining expected %0d actual %0d",
                     $time, want.remaining, got.remaining);
         end
         if (got.mark_set !== want.mark_set) begin
            errors++;
            $display("%0t: mark_set expected %0d actual %0d",
                     $time, want.mark_set, got.mark_set);
         end
      endfunction
   endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import dsa_pkg::*;
   import dsa_tb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   dsa_req_type           req_data;
   logic                  rsp_valid;
   dsa_rsp_type           rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   alloc_scoreboard sb = new();
   temp_block_type  live_temps[$];
   int              op_count[8];
   int              settings_done;
   bit              no_idle;

   double_ended_stack_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_data);
   end

   function automatic logic [TOTAL_W-1:0] temp_span(logic [SIZE_W-1:0] size);
      logic [63:0] s;
      s = ((64'(size) + 64'(TEMP_ALIGN)) & ~64'(TEMP_ALIGN)) + 64'(HDR_BYTES);
      return s[TOTAL_W-1:0];
   endfunction

   function automatic dsa_req_type make_request(logic [2:0] op, logic [SIZE_W-1:0] size,
                                                logic [1:0] pref, logic [ADDR_W-1:0] buf_addr,
                                                logic [TOTAL_W-1:0] rsz);
      dsa_req_type r;
      r.req_type       = op;
      r.alloc_size     = size;
      r.preference     = pref;
      r.buffer_address = buf_addr;
      r.recorded_size  = rsz;
      return r;
   endfunction

   // Free of the most recent temp buffer still outstanding
   function automatic dsa_req_type free_top_request();
      dsa_req_type r;
      r = make_request(OP_FREE_TEMP, SIZE_W'($urandom), PREF_ANY, $urandom, '0);
      if (live_temps.size() > 0) begin
         r.buffer_address = live_temps[live_temps.size()-1].addr;
         r.recorded_size  = live_temps[live_temps.size()-1].span;
      end
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70)
         return SIZE_W'($urandom_range(0, 255));
      else if (sel < 90)
         return SIZE_W'($urandom_range(0, 8191));
      else if (sel < 97)
         return SIZE_W'($urandom_range(0, 1 << 20));
      return SIZE_W'($urandom);
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
         return 0;
      else if (sel < 90)
         return $urandom_range(1, 3);
      else if (sel < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic dsa_req_type make_random_request();
      dsa_req_type r;
      int          sel;
      int          k;
      int          idx;
      sel = $urandom_range(0, 99);
      r = make_request(OP_ALLOC_PERM, pick_size(),
                       ($urandom_range(0, 99) < 4) ? PREF_NONE : 2'($urandom_range(0, 2)),
                       $urandom, TOTAL_W'($urandom_range(0, 1 << 28)));
      if (sel < 24) begin
         r.req_type = OP_ALLOC_PERM;
      end else if (sel < 52) begin
         r.req_type = OP_ALLOC_TEMP;
      end else if (sel < 72) begin
         k = $urandom_range(0, 99);
         if (live_temps.size() > 0 && k < 85) begin
            r = free_top_request();
         end else if (live_temps.size() > 1 && k < 93) begin
            // buried buffer: must be refused
            r.req_type = OP_FREE_TEMP;
            idx = $urandom_range(0, live_temps.size() - 2);
            r.buffer_address = live_temps[idx].addr;
            r.recorded_size  = live_temps[idx].span;
         end else if (live_temps.size() > 0 && k < 97) begin
            r = free_top_request();
            r.recorded_size = r.recorded_size + TOTAL_W'(8);
         end else begin
            r.req_type = OP_FREE_TEMP;
         end
      end else if (sel < 76) begin
         r.req_type = OP_CLR_TEMP;
      end else if (sel < 83) begin
         r.req_type = OP_SET_MARK;
      end else if (sel < 88) begin
         r.req_type = OP_CLR_MARK;
      end else if (sel < 91) begin
         r.req_type = OP_CLR_ALL;
      end else if (sel < 93) begin
         r.req_type = OP_UNDEFINED;
      end
      return r;
   endfunction

   // Enter and leave at a falling edge; start stays high when gap is zero
   task automatic send_request(input dsa_req_type r, input int gap);
      dsa_rsp_type    want;
      temp_block_type blk;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      want = sb.note_request(r);
      op_count[r.req_type]++;
      case (r.req_type)
         OP_ALLOC_TEMP: begin
            if (want.status == STATUS_OK) begin
               blk.addr = want.address;
               blk.span = temp_span(r.alloc_size);
               live_temps.push_back(blk);
            end
         end
         OP_FREE_TEMP: begin
            if (want.status == STATUS_OK && live_temps.size() > 0)
               void'(live_temps.pop_back());
         end
         OP_CLR_TEMP, OP_CLR_MARK, OP_CLR_ALL: begin
            live_temps.delete();
         end
         default: ;
      endcase
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_results_done();
      int n;
      n = 0;
      while (sb.pending() != 0 && n < 2000) begin
         @(negedge clock);
         n++;
      end
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_directed();
      send_request(make_request(OP_ALLOC_PERM, '0, PREF_LOW, '0, '0), 0);
      send_request(make_request(OP_ALLOC_PERM, 28'd1, PREF_ANY, '0, '0), 1);
      send_request(make_request(OP_ALLOC_PERM, 28'hFFF_FFFF, PREF_LOW, 32'hFFFF_FFFF,
                                29'h1000_0000), 0);
      send_request(make_request(OP_ALLOC_TEMP, '0, PREF_LOW, '0, '0), 2);
      send_request(make_request(OP_ALLOC_TEMP, 28'd13, PREF_HIGH, '0, '0), 0);
      send_request(free_top_request(), 1);
      send_request(make_request(OP_FREE_TEMP, '0, PREF_ANY, 32'hFFFF_FFFF, 29'd8), 0);
      send_request(make_request(OP_FREE_TEMP, '0, PREF_ANY, '0, 29'h1000_0000), 0);
      send_request(free_top_request(), 0);
      send_request(make_request(OP_SET_MARK, '0, PREF_ANY, '0, '0), 1);
      send_request(make_request(OP_ALLOC_PERM, 28'd100, PREF_HIGH, '0, '0), 0);
      send_request(make_request(OP_ALLOC_TEMP, 28'd64, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_CLR_MARK, '0, PREF_ANY, '0, '0), 3);
      send_request(make_request(OP_ALLOC_TEMP, 28'hFFF_FFFF, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_ALLOC_TEMP, 28'd40, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_CLR_TEMP, '0, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_ALLOC_PERM, 28'd40, PREF_NONE, '0, '0), 1);
      send_request(make_request(OP_UNDEFINED, 28'hFFF_FFFF, PREF_NONE, 32'hFFFF_FFFF,
                                29'h1000_0000), 0);
      // a freed temp leaves high-water waste that should pull the permanent role over
      send_request(make_request(OP_ALLOC_TEMP, 28'd200, PREF_ANY, '0, '0), 0);
      send_request(free_top_request(), 0);
      send_request(make_request(OP_ALLOC_PERM, 28'd32, PREF_ANY, '0, '0), 1);
      send_request(make_request(OP_ALLOC_TEMP, 28'd24, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_CLR_ALL, '0, PREF_ANY, '0, '0), 0);
      send_request(make_request(OP_ALLOC_PERM, 28'd5, PREF_HIGH, '0, '0), 1);
   endtask

   task automatic run_random_phase(input logic [ADDR_W-1:0] base,
                                   input logic [TOTAL_W-1:0] total, input int n);
      dsa_req_type r;
      int          gap;
      write_csr(REG_BASE, base);
      write_csr(REG_TOTAL, CSR_DATA_W'(total));
      settings_done++;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         r = make_random_request();
         if (i == 0 && $urandom_range(0, 1) == 1)
            r.req_type = OP_CLR_ALL;
         gap = no_idle ? 0 : pick_gap();
         // drop start before a hold-off
         if (i == n / 2 || i == n - 1)
            gap = gap + 1;
         send_request(r, gap);
         if (i == n / 2)
            wait_results_done();
      end
      wait_results_done();
   endtask

   initial begin
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      settings_done = 0;
      no_idle = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      wait_results_done();

      run_random_phase(32'hFFFF_FFFF, 29'h1000_0000, 150);
      run_random_phase($urandom, 29'd4096, 150);
      run_random_phase(32'h0, 29'd0, 150);
      run_random_phase($urandom, 29'd600, 150);
      run_random_phase($urandom, TOTAL_W'($urandom_range(1024, 65536)), 150);
      run_random_phase(32'h8000_0000, TOTAL_RESET, 150);
      run_random_phase($urandom, 29'd2048, 150);

      repeat (20) @(negedge clock);
      $display("Covered %0d permanent and %0d temporary allocations, %0d frees, %0d other",
               op_count[OP_ALLOC_PERM], op_count[OP_ALLOC_TEMP], op_count[OP_FREE_TEMP],
               op_count[OP_CLR_TEMP] + op_count[OP_SET_MARK] + op_count[OP_CLR_MARK] +
               op_count[OP_CLR_ALL] + op_count[OP_UNDEFINED]);
      $display("over %0d register settings; %0d results checked, %0d mismatches",
               settings_done, sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS double_ended_stack_allocator");
      else
         $display("FAIL double_ended_stack_allocator");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL double_ended_stack_allocator");
      $finish;
   end

endmodule
